// ===== rtl/hsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared constants, codes, types and helpers of the hard-sectored floppy
// controller.
// ----------------------------------------------------------------------------
package hsfc_pkg;

    localparam int DRIVES            = 8;
    localparam int TRACK_COUNT       = 254;
    localparam int SECTORS_PER_TRACK = 32;
    localparam int SECTOR_BYTES      = 137;

    localparam int TRK_BYTES   = SECTORS_PER_TRACK * SECTOR_BYTES;
    localparam int IMG_BYTES   = TRACK_COUNT * TRK_BYTES;
    localparam int STORE_BYTES = DRIVES * IMG_BYTES;

    localparam int IMG_AW = 24;                         // image_address width
    localparam int OFF_W  = $clog2(IMG_BYTES) + 1;      // room for offsets past the image
    localparam int SEL_W  = $clog2(DRIVES + 1);         // drive number or "no drive"
    localparam int DIDX_W = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int BI_W   = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;

    localparam logic [7:0] BP_MARK     = 8'hff;
    localparam logic [7:0] ST_SEL_T0   = 8'h5a;
    localparam logic [7:0] ST_SEL      = 8'h1a;
    localparam logic [7:0] POS_MASK    = 8'h3e;
    localparam logic [7:0] POS_MARK    = 8'hc0;
    localparam logic [7:0] ST_CLR_WE   = 8'hfe;
    localparam logic [7:0] ST_UNLOAD   = 8'hfb & 8'h7f;
    localparam logic [7:0] ST_TRACK0   = 8'h40;
    localparam logic [7:0] ST_LOAD     = 8'h84;
    localparam logic [7:0] ST_WE       = 8'h01;
    localparam logic [7:0] NO_DRIVE_ST = 8'hff;

    localparam logic       KIND_PORT = 1'b0;
    localparam logic       KIND_LOAD = 1'b1;
    localparam logic [1:0] PORT_SEL  = 2'd0;
    localparam logic [1:0] PORT_CTL  = 2'd1;
    localparam logic [1:0] PORT_DATA = 2'd2;
    localparam logic       CFG_ATTACHED = 1'b0;
    localparam logic       CFG_LOCKED   = 1'b1;

    typedef enum logic [1:0] {
        JOB_READ,
        JOB_WRITE,
        JOB_FLUSH,
        JOB_FETCH
    } job_op_t;

    typedef enum logic [2:0] {
        X_IDLE,
        X_SETUP,
        X_FLUSH,
        X_FETCH,
        X_DRAIN,
        X_RDISSUE,
        X_RDWAIT,
        X_DONE
    } xfer_state_t;

    typedef struct packed {
        job_op_t           op;
        logic [DIDX_W-1:0] drive;
        logic [7:0]        track;
        logic [7:0]        sector;
        logic [7:0]        bp;      // pad start for flush, byte index for read/write
        logic              lock;
        logic [7:0]        wdata;
    } job_t;

    typedef struct packed {
        logic       done;
        logic [7:0] rdata;
    } xfer_stat_t;

    typedef struct packed {
        logic            we;
        logic [BI_W-1:0] waddr;
        logic [7:0]      wdata;
        logic            re;
        logic [BI_W-1:0] raddr;
    } buf_req_t;

    typedef struct packed {
        logic              we;
        logic [IMG_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [IMG_AW-1:0] raddr;
    } img_req_t;

    // drive number reduced modulo DRIVES, small table over a nibble
    function automatic logic [DIDX_W-1:0] mod_drives(input logic [3:0] v);
        logic [DIDX_W-1:0] r;
        r = '0;
        for (int k = 0; k < 16; k++)
            if (v == 4'(k))
                r = DIDX_W'(k % DRIVES);
        return r;
    endfunction

    // only drives 0..7 have a mask bit
    function automatic logic drive_bit(input logic [7:0] mask, input logic [SEL_W-1:0] idx);
        logic b;
        b = 1'b0;
        for (int k = 0; k < 8; k++)
            if (k < DRIVES && idx == SEL_W'(k))
                b = mask[k];
        return b;
    endfunction

endpackage

// ===== rtl/hard_sector_floppy_controller_core.sv =====
// ----------------------------------------------------------------------------
// hard_sector_floppy_controller_core
// Three-port hard-sectored floppy controller for up to eight drives with the
// disk images in an internal byte store.
// Image loads and port accesses that start no transfer give their beat in the
//   cycle after acceptance; a buffered data read passes X_RDWAIT and X_DONE.
// A sector fetch or flush walks the 137 buffer bytes one a cycle through the
//   image store port, and a fetch then reads the first buffer byte.
// Throughput: one item at a time; the next is taken when the result moves.
// Reset clears drive state, selection, masks and buffer (through valid
//   bits); the image store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module hard_sector_floppy_controller_core
    import hsfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // data[7:0], image_address[31:8]
    input  logic [3:0]  s_tuser,    // kind[0], port[2:1], is_write[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // read_data[7:0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // per-drive state and selection
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [7:0]       track_reg [DRIVES];
    logic [7:0]       track_next [DRIVES];
    logic [7:0]       sp_reg [DRIVES];
    logic [7:0]       sp_next [DRIVES];
    logic [7:0]       bp_reg [DRIVES];
    logic [7:0]       bp_next [DRIVES];
    logic [7:0]       st_reg [DRIVES];
    logic [7:0]       st_next [DRIVES];
    logic             dirty_reg, dirty_next;
    logic [7:0]       attached_reg, locked_reg;

    // result and job tracking
    logic             busy_reg;
    logic             job_rd_reg;
    logic [7:0]       pend_res_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;

    // input beat fields
    logic              in_kind, in_wr, in_acc;
    logic [1:0]        in_port;
    logic [7:0]        in_data;
    logic [IMG_AW-1:0] in_addr;

    logic              ack;
    logic              job_start;
    job_t              job;
    logic [7:0]        res;
    logic              load_we;

    // decode helpers
    logic [DIDX_W-1:0] d, nd;
    logic              dv, lock;
    logic [7:0]        t, sp, bp, st, t1, t2, s8;
    logic [8:0]        t9, s9;

    xfer_stat_t xstat;
    buf_req_t   buf_req;
    img_req_t   xfer_img, img_req;
    logic [7:0] buf_rdata, img_rdata;

    assign in_kind = s_tuser[0];
    assign in_port = s_tuser[2:1];
    assign in_wr   = s_tuser[3];
    assign in_data = s_tdata[7:0];
    assign in_addr = s_tdata[31:8];

    // a result may leave while a new one is loaded
    assign ack      = !m_valid_reg || m_tready;
    assign s_tready = !busy_reg && ack;
    assign in_acc   = s_tvalid && s_tready;

    assign load_we = in_acc && (in_kind == KIND_LOAD) && (in_addr < IMG_AW'(STORE_BYTES));

    always_comb
    begin
        sel_next   = sel_reg;
        dirty_next = dirty_reg;
        track_next = track_reg;
        sp_next    = sp_reg;
        bp_next    = bp_reg;
        st_next    = st_reg;
        job_start  = 1'b0;
        res        = 8'h00;

        d    = sel_reg[DIDX_W-1:0];
        dv   = (sel_reg < SEL_W'(DRIVES));
        t    = track_reg[d];
        sp   = sp_reg[d];
        bp   = bp_reg[d];
        st   = st_reg[d];
        lock = drive_bit(locked_reg, sel_reg);
        nd   = mod_drives(in_data[3:0]);

        // step in clamps at the last track, step out at track 0
        t9 = {1'b0, t} + 9'd1;
        t1 = in_data[0] ? ((t9 <= 9'(TRACK_COUNT - 1)) ? t9[7:0] : 8'(TRACK_COUNT - 1)) : t;
        t2 = (in_data[1] && t1 != 8'h00) ? t1 - 8'd1 : t1;

        // sector counter wraps at the track end; the mark value wraps too
        s9 = {1'b0, sp} + 9'd1;
        s8 = (s9 >= 9'(SECTORS_PER_TRACK)) ? 8'h00 : s9[7:0];

        job.op     = JOB_FLUSH;
        job.drive  = d;
        job.track  = t;
        job.sector = sp;
        job.bp     = bp;
        job.lock   = lock;
        job.wdata  = in_data;

        if (in_acc && in_kind == KIND_PORT)
        begin
            case (in_port)
                PORT_SEL:
                begin
                    if (!in_wr)
                    begin
                        res = dv ? ~st : NO_DRIVE_ST;
                    end
                    else
                    begin
                        // pending writes go to the old drive first
                        if (dirty_reg && dv)
                        begin
                            job_start = 1'b1;
                            st_next[d] = st & ST_CLR_WE;
                            bp_next[d] = BP_MARK;
                        end
                        dirty_next = 1'b0;
                        if (drive_bit(attached_reg, SEL_W'(nd)))
                        begin
                            sel_next    = SEL_W'(nd);
                            sp_next[nd] = BP_MARK;
                            bp_next[nd] = BP_MARK;
                            st_next[nd] = in_data[7] ? 8'h00 :
                                          ((track_reg[nd] == 8'h00) ? ST_SEL_T0 : ST_SEL);
                        end
                        else
                        begin
                            sel_next = SEL_W'(DRIVES);
                        end
                    end
                end
                PORT_CTL:
                begin
                    if (dv && !in_wr)
                    begin
                        if (dirty_reg)
                        begin
                            job_start  = 1'b1;
                            dirty_next = 1'b0;
                            st_next[d] = st & ST_CLR_WE;
                            bp_next[d] = BP_MARK;
                        end
                        if (st[2])
                        begin
                            sp_next[d] = s8;
                            bp_next[d] = BP_MARK;
                            res = ({s8[6:0], 1'b0} & POS_MASK) | POS_MARK;
                        end
                    end
                    else if (dv)
                    begin
                        // a flush here sees the stepped track and the old sector
                        job.track     = in_data[0] ? t1 : t2;
                        track_next[d] = t2;
                        job_start     = dirty_reg;
                        dirty_next    = 1'b0;
                        st_next[d]    = st;
                        if (dirty_reg)
                            st_next[d] = st_next[d] & ST_CLR_WE;
                        if (in_data[1] && t1 == 8'h00)
                            st_next[d] = st_next[d] | ST_TRACK0;
                        if (in_data[2])
                            st_next[d] = st_next[d] | ST_LOAD;
                        if (in_data[3])
                            st_next[d] = st_next[d] & ST_UNLOAD;
                        if (in_data[7])
                            st_next[d] = st_next[d] | ST_WE;
                        if (in_data[0] || in_data[1] || in_data[3])
                            sp_next[d] = BP_MARK;
                        if (in_data[0] || in_data[1] || in_data[3] || dirty_reg)
                            bp_next[d] = BP_MARK;
                        if (in_data[7])
                            bp_next[d] = 8'h00;
                    end
                end
                PORT_DATA:
                begin
                    if (dv)
                    begin
                        job_start = 1'b1;
                        if (!in_wr)
                        begin
                            if (bp >= 8'(SECTOR_BYTES))
                            begin
                                job.op     = JOB_FETCH;
                                job.bp     = 8'h00;
                                bp_next[d] = 8'h01;
                            end
                            else
                            begin
                                job.op     = JOB_READ;
                                bp_next[d] = bp + 8'd1;
                            end
                        end
                        else if (bp >= 8'(SECTOR_BYTES))
                        begin
                            job.op     = JOB_FLUSH;
                            st_next[d] = st & ST_CLR_WE;
                            bp_next[d] = BP_MARK;
                            dirty_next = 1'b0;
                        end
                        else
                        begin
                            job.op     = JOB_WRITE;
                            dirty_next = 1'b1;
                            bp_next[d] = bp + 8'd1;
                        end
                    end
                end
                default:
                begin
                    res = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg      <= SEL_W'(DRIVES);
            dirty_reg    <= 1'b0;
            attached_reg <= '0;
            locked_reg   <= '0;
            busy_reg     <= 1'b0;
            job_rd_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < DRIVES; i++)
            begin
                track_reg[i] <= 8'h00;
                sp_reg[i]    <= 8'h00;
                bp_reg[i]    <= 8'h00;
                st_reg[i]    <= 8'h00;
            end
        end
        else
        begin
            sel_reg   <= sel_next;
            dirty_reg <= dirty_next;
            track_reg <= track_next;
            sp_reg    <= sp_next;
            bp_reg    <= bp_next;
            st_reg    <= st_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ATTACHED: attached_reg <= cfg_data;
                    CFG_LOCKED:   locked_reg   <= cfg_data;
                    default:      attached_reg <= attached_reg;
                endcase
            end

            if (job_start)
            begin
                busy_reg   <= 1'b1;
                job_rd_reg <= (job.op == JOB_READ) || (job.op == JOB_FETCH);
            end
            else if (xstat.done && ack)
            begin
                busy_reg <= 1'b0;
            end

            if ((in_acc && !job_start) || (xstat.done && ack))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_start)
        begin
            pend_res_reg <= in_wr ? 8'h00 : res;
        end
        if (in_acc && !job_start)
        begin
            m_data_reg <= in_wr ? 8'h00 : res;
        end
        else if (xstat.done && ack)
        begin
            m_data_reg <= job_rd_reg ? xstat.rdata : pend_res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // image loads only happen while the sequencer is idle
    always_comb
    begin
        img_req = xfer_img;
        if (load_we)
        begin
            img_req.we    = 1'b1;
            img_req.waddr = in_addr;
            img_req.wdata = in_data;
        end
    end

    hsfc_xfer u_xfer (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (job_start),
        .job       (job),
        .ack       (ack),
        .stat      (xstat),
        .buf_req   (buf_req),
        .buf_rdata (buf_rdata),
        .img_req   (xfer_img),
        .img_rdata (img_rdata)
    );

    hsfc_sector_buf u_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (buf_req),
        .rdata (buf_rdata)
    );

    hsfc_image_ram u_img (
        .clk   (clk),
        .req   (img_req),
        .rdata (img_rdata)
    );

endmodule

// ===== rtl/hsfc_image_ram.sv =====
// ----------------------------------------------------------------------------
// hsfc_image_ram
// Disk image store for all drives, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsfc_image_ram
    import hsfc_pkg::*;
(
    input  logic       clk,
    input  img_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem [0:STORE_BYTES-1];
    logic [7:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_reg <= mem[req.raddr];
        end
    end

    assign rdata = rd_reg;

endmodule

// ===== rtl/hsfc_sector_buf.sv =====
// ----------------------------------------------------------------------------
// hsfc_sector_buf
// Sector buffer memory; entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module hsfc_sector_buf
    import hsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  buf_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0]              mem [0:SECTOR_BYTES-1];
    logic [SECTOR_BYTES-1:0] valid_reg;
    logic [7:0]              rd_reg;
    logic                    rv_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rv_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = rv_reg ? rd_reg : 8'h00;

endmodule

// ===== rtl/hsfc_xfer.sv =====
// ----------------------------------------------------------------------------
// hsfc_xfer
// Transfer sequencer: sector fetch, flush (pad and commit), buffer byte
// read and write. One byte a cycle through a read pipeline: issue, then write.
// ----------------------------------------------------------------------------
module hsfc_xfer
    import hsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  job_t       job,
    input  logic       ack,
    output xfer_stat_t stat,
    output buf_req_t   buf_req,
    input  logic [7:0] buf_rdata,
    output img_req_t   img_req,
    input  logic [7:0] img_rdata
);

    xfer_state_t       state_reg, state_next;
    job_t              job_reg;
    logic [IMG_AW-1:0] drv_base_reg;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [IMG_AW-1:0] addr_reg, addr_next;
    logic [BI_W-1:0]   idx_reg, idx_next;
    logic [7:0]        rdata_reg, rdata_next;

    // second stage: memory data is back
    logic              p_valid_reg, p_valid_next;
    logic [BI_W-1:0]   p_idx_reg, p_idx_next;
    logic [IMG_AW-1:0] p_addr_reg, p_addr_next;
    logic              p_inr_reg, p_inr_next;
    logic              p_pad_reg, p_pad_next;

    logic              in_range;

    assign in_range = (off_reg < OFF_W'(IMG_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= X_IDLE;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == X_IDLE && start)
        begin
            job_reg      <= job;
            drv_base_reg <= IMG_AW'(job.drive * IMG_BYTES);
            off_reg      <= OFF_W'(job.track * TRK_BYTES + job.sector * SECTOR_BYTES);
        end
        else
        begin
            off_reg <= off_next;
        end
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        rdata_reg  <= rdata_next;
        p_idx_reg  <= p_idx_next;
        p_addr_reg <= p_addr_next;
        p_inr_reg  <= p_inr_next;
        p_pad_reg  <= p_pad_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        off_next     = off_reg;
        addr_next    = addr_reg;
        idx_next     = idx_reg;
        rdata_next   = rdata_reg;
        p_valid_next = 1'b0;
        p_idx_next   = idx_reg;
        p_addr_next  = addr_reg;
        p_inr_next   = in_range;
        p_pad_next   = (8'(idx_reg) >= job_reg.bp);
        buf_req      = '0;
        img_req      = '0;

        case (state_reg)
            X_IDLE:
            begin
                if (start)
                begin
                    case (job.op)
                        JOB_READ:
                        begin
                            buf_req.re    = 1'b1;
                            buf_req.raddr = job.bp[BI_W-1:0];
                            state_next    = X_RDWAIT;
                        end
                        JOB_WRITE:
                        begin
                            buf_req.we    = 1'b1;
                            buf_req.waddr = job.bp[BI_W-1:0];
                            buf_req.wdata = job.wdata;
                            state_next    = X_DONE;
                        end
                        default:
                        begin
                            state_next = X_SETUP;
                        end
                    endcase
                end
            end
            X_SETUP:
            begin
                addr_next  = drv_base_reg + IMG_AW'(off_reg);
                idx_next   = '0;
                state_next = (job_reg.op == JOB_FLUSH) ? X_FLUSH : X_FETCH;
            end
            X_FLUSH, X_FETCH:
            begin
                if (state_reg == X_FLUSH)
                begin
                    buf_req.re    = 1'b1;
                    buf_req.raddr = idx_reg;
                end
                else
                begin
                    img_req.re    = in_range;
                    img_req.raddr = addr_reg;
                end
                p_valid_next = 1'b1;
                idx_next     = idx_reg + 1'b1;
                addr_next    = addr_reg + 1'b1;
                off_next     = off_reg + 1'b1;
                if (idx_reg == BI_W'(SECTOR_BYTES - 1))
                begin
                    state_next = X_DRAIN;
                end
            end
            X_DRAIN:
            begin
                state_next = (job_reg.op == JOB_FETCH) ? X_RDISSUE : X_DONE;
            end
            X_RDISSUE:
            begin
                buf_req.re    = 1'b1;
                buf_req.raddr = '0;
                state_next    = X_RDWAIT;
            end
            X_RDWAIT:
            begin
                rdata_next = buf_rdata;
                state_next = X_DONE;
            end
            X_DONE:
            begin
                if (ack)
                begin
                    state_next = X_IDLE;
                end
            end
            default:
            begin
                state_next = X_IDLE;
            end
        endcase

        // second stage writes
        if (p_valid_reg)
        begin
            if (job_reg.op == JOB_FLUSH)
            begin
                if (p_pad_reg)
                begin
                    buf_req.we    = 1'b1;
                    buf_req.waddr = p_idx_reg;
                    buf_req.wdata = 8'h00;
                end
                if (!job_reg.lock && p_inr_reg)
                begin
                    img_req.we    = 1'b1;
                    img_req.waddr = p_addr_reg;
                    img_req.wdata = p_pad_reg ? 8'h00 : buf_rdata;
                end
            end
            else
            begin
                buf_req.we    = 1'b1;
                buf_req.waddr = p_idx_reg;
                buf_req.wdata = p_inr_reg ? img_rdata : 8'h00;
            end
        end
    end

    assign stat.done  = (state_reg == X_DONE);
    assign stat.rdata = rdata_reg;

endmodule

// ===== rtl/hsfc_checker.sv =====
// ----------------------------------------------------------------------------
// hsfc_checker
// Port-level checks of the floppy controller stream behavior.
// ----------------------------------------------------------------------------
module hsfc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [3:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no new beat taken while a result is stuck
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken with output stalled");

    // an image load answers zero on the next cycle
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> m_tvalid && m_tdata == 8'h00)
        else $error("image load result wrong");

endmodule

bind hard_sector_floppy_controller_core hsfc_checker u_chk (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the hard-sectored floppy controller core. A behavioral copy of the
// controller predicts each returned byte. The stimulus has directed checks of
// select, step, head load, the sector counter and buffer read/write, then runs
// random phases of well-formed drive sessions mixed with noise beats, the masks
// changed between phases. Both stream sides stall at random, save in the last.
// ----------------------------------------------------------------------------
module testbench;
    import hsfc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // data[7:0], image_address[31:8]
    logic [3:0]  s_tuser;   // kind[0], port[2:1], is_write[3]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // read_data[7:0]
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_data;

    hard_sector_floppy_controller_core dut (.*);

    localparam logic [1:0] PORT_NONE = 2'd3;   // unused port number
    localparam int         NO_SEL    = DRIVES;

    // controller state as the testbench sees it
    logic [7:0] attached_q, locked_q;
    int         sel_drive;
    logic [7:0] trk [DRIVES];
    logic [7:0] spos[DRIVES];
    logic [7:0] bptr[DRIVES];
    logic [7:0] dstat[DRIVES];
    logic [7:0] sbuf[SECTOR_BYTES];
    logic       dirty;
    logic [7:0] image_bytes[int];   // only entries written so far

    logic [7:0] read_bytes_q[$];    // expected read_data per beat
    int         errors;
    int         beats_sent;
    bit         quiet;              // no idling on the input side

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch: %s got %02h want %02h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------------------------------------------------------- predictor
    function automatic int sector_offset(input int d);
        return int'(trk[d]) * TRK_BYTES + int'(spos[d]) * SECTOR_BYTES;
    endfunction

    function automatic void commit_sector();
        int d, off;
        d = sel_drive;
        if (d >= DRIVES)
        begin
            dirty = 1'b0;
            return;
        end
        for (int i = int'(bptr[d]); i < SECTOR_BYTES; i++)
            sbuf[i] = 8'h00;
        if (!locked_q[d])
        begin
            off = sector_offset(d);
            for (int i = 0; i < SECTOR_BYTES; i++)
                if (off + i < IMG_BYTES)
                    image_bytes[d * IMG_BYTES + off + i] = sbuf[i];
        end
        dstat[d] &= ST_CLR_WE;
        bptr[d] = BP_MARK;
        dirty = 1'b0;
    endfunction

    // a data read here would pull in image bytes never loaded nor committed
    function automatic bit fetch_unknown();
        int d, off;
        d = sel_drive;
        if (d >= DRIVES || bptr[d] < SECTOR_BYTES)
            return 1'b0;
        off = sector_offset(d);
        for (int i = 0; i < SECTOR_BYTES; i++)
            if (off + i < IMG_BYTES && !image_bytes.exists(d * IMG_BYTES + off + i))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] select_port(input bit wr, input logic [7:0] data);
        int d;
        if (!wr)
            return (sel_drive >= DRIVES) ? NO_DRIVE_ST : ~dstat[sel_drive];
        if (dirty)
            commit_sector();
        d = int'(data[3:0]) % DRIVES;
        if (!attached_q[d])
        begin
            sel_drive = NO_SEL;
            return 8'h00;
        end
        sel_drive = d;
        spos[d] = BP_MARK;
        bptr[d] = BP_MARK;
        dstat[d] = data[7] ? 8'h00 : ((trk[d] == 0) ? ST_SEL_T0 : ST_SEL);
        return 8'h00;
    endfunction

    function automatic logic [7:0] control_port(input bit wr, input logic [7:0] data);
        int d, s;
        d = sel_drive;
        if (d >= DRIVES)
            return 8'h00;
        if (!wr)
        begin
            if (dirty)
                commit_sector();
            if ((dstat[d] & 8'h04) == 0)
                return 8'h00;
            s = int'(spos[d]) + 1;
            if (s >= SECTORS_PER_TRACK)
                s = 0;
            spos[d] = 8'(s);
            bptr[d] = BP_MARK;
            return (8'(s << 1) & POS_MASK) | POS_MARK;
        end
        if (data[0])
        begin
            if (int'(trk[d]) + 1 <= TRACK_COUNT - 1)
                trk[d]++;
            else
                trk[d] = 8'(TRACK_COUNT - 1);
            if (dirty)
                commit_sector();
            spos[d] = BP_MARK;
            bptr[d] = BP_MARK;
        end
        if (data[1])
        begin
            if (trk[d] == 0)
                dstat[d] |= ST_TRACK0;
            else
                trk[d]--;
            if (dirty)
                commit_sector();
            spos[d] = BP_MARK;
            bptr[d] = BP_MARK;
        end
        if (dirty)
            commit_sector();
        if (data[2])
            dstat[d] |= ST_LOAD;
        if (data[3])
        begin
            dstat[d] &= ST_UNLOAD;
            spos[d] = BP_MARK;
            bptr[d] = BP_MARK;
        end
        if (data[7])
        begin
            bptr[d] = 8'h00;
            dstat[d] |= ST_WE;
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] data_port(input bit wr, input logic [7:0] data);
        int d, off;
        logic [7:0] v;
        d = sel_drive;
        if (d >= DRIVES)
            return 8'h00;
        if (!wr)
        begin
            if (bptr[d] >= SECTOR_BYTES)
            begin
                off = sector_offset(d);
                for (int i = 0; i < SECTOR_BYTES; i++)
                    sbuf[i] = (off + i < IMG_BYTES) ? image_bytes[d * IMG_BYTES + off + i]
                                                    : 8'h00;
                bptr[d] = 8'h00;
            end
            v = sbuf[bptr[d]];
            bptr[d]++;
            return v;
        end
        if (bptr[d] >= SECTOR_BYTES)
            commit_sector();
        else
        begin
            dirty = 1'b1;
            sbuf[bptr[d]] = data;
            bptr[d]++;
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] predict_beat(input bit kind, input logic [1:0] port,
                                                input bit wr, input logic [7:0] data,
                                                input logic [23:0] addr);
        logic [7:0] r;
        r = 8'h00;
        if (kind == KIND_LOAD)
        begin
            if (int'(addr) < STORE_BYTES)
                image_bytes[int'(addr)] = data;
        end
        else if (port == PORT_SEL)
            r = select_port(wr, data);
        else if (port == PORT_CTL)
            r = control_port(wr, data);
        else if (port == PORT_DATA)
            r = data_port(wr, data);
        return wr ? 8'h00 : r;
    endfunction

    // ---------------------------------------------------------------- driving
    // Sends one beat. Valid stays high on return unless a gap was taken, so the
    // next call may follow in the same step without a second assignment.
    task automatic send_beat(input bit kind, input logic [1:0] port, input bit wr,
                             input logic [7:0] data, input logic [23:0] addr);
        // never read a sector the store has not seen; flush in place instead
        if (kind == KIND_PORT && port == PORT_DATA && !wr && fetch_unknown())
        begin
            port = PORT_CTL;
            wr   = 1'b1;
            data = 8'h00;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, data};
        s_tuser  <= {wr, port, kind};
        read_bytes_q.push_back(predict_beat(kind, port, wr, data, addr));
        beats_sent++;
        do
            @(posedge clk);
        while (!s_tready);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic port_beat(input logic [1:0] port, input bit wr, input logic [7:0] data);
        send_beat(KIND_PORT, port, wr, data, 24'($urandom));
    endtask

    // hold off until every expected byte is back, then let the core settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (read_bytes_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_masks(input logic [7:0] attached, input logic [7:0] locked);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ATTACHED;
        cfg_data  <= attached;
        @(posedge clk);
        cfg_index <= CFG_LOCKED;
        cfg_data  <= locked;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        attached_q = attached;
        locked_q   = locked;
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        // nothing attached: no drive
        port_beat(PORT_SEL, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b0, 8'h00);
        port_beat(PORT_DATA, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b1, 8'hff);
        port_beat(PORT_NONE, 1'b0, 8'h55);
        port_beat(PORT_SEL, 1'b1, 8'h03);
        send_beat(KIND_LOAD, PORT_SEL, 1'b0, 8'hff, 24'hffffff);   // past the store
        send_beat(KIND_LOAD, PORT_SEL, 1'b1, 8'ha5, 24'(STORE_BYTES - 1));
        write_masks(8'hff, 8'h02);
        port_beat(PORT_SEL, 1'b1, 8'h80);         // status forced to zero
        port_beat(PORT_SEL, 1'b0, 8'h00);
        port_beat(PORT_SEL, 1'b1, 8'h08);         // drive 8 wraps to drive 0
        port_beat(PORT_SEL, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b0, 8'h00);         // head unloaded: no advance
        port_beat(PORT_CTL, 1'b1, 8'h06);         // load head, step out at track 0
        port_beat(PORT_CTL, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b1, 8'h01);
        port_beat(PORT_CTL, 1'b1, 8'h02);         // back to track 0 from track 1
        port_beat(PORT_SEL, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b1, 8'h80);
        port_beat(PORT_DATA, 1'b1, 8'h00);
        port_beat(PORT_DATA, 1'b1, 8'hff);
        port_beat(PORT_CTL, 1'b1, 8'h00);         // flush with zero pad
        repeat (3) port_beat(PORT_DATA, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b1, 8'h08);         // unload
        port_beat(PORT_CTL, 1'b0, 8'h00);
        // locked drive: flush refused
        port_beat(PORT_SEL, 1'b1, 8'h01);
        port_beat(PORT_CTL, 1'b1, 8'h84);
        port_beat(PORT_DATA, 1'b1, 8'h3c);
        port_beat(PORT_DATA, 1'b1, 8'hc3);        // a second byte into the buffer
        port_beat(PORT_SEL, 1'b0, 8'h00);
    endtask

    task automatic test_track_limits();
        port_beat(PORT_SEL, 1'b1, 8'h02);
        repeat (TRACK_COUNT + 1) port_beat(PORT_CTL, 1'b1, 8'h01);
        port_beat(PORT_SEL, 1'b1, 8'h02);         // sector counter at its mark
        port_beat(PORT_DATA, 1'b0, 8'h00);        // whole sector past the image
        port_beat(PORT_CTL, 1'b1, 8'h80);
        port_beat(PORT_DATA, 1'b1, 8'h5a);
        port_beat(PORT_CTL, 1'b1, 8'h03);         // step in, step out, flush dropped
        port_beat(PORT_SEL, 1'b1, 8'h02);
        port_beat(PORT_DATA, 1'b0, 8'h00);
        port_beat(PORT_SEL, 1'b0, 8'h00);         // drive stays near the last track
    endtask

    // one drive session: select, load, pick a sector, write, flush, read back
    task automatic drive_session();
        logic [7:0] sel_data;
        sel_data = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 7) == 0)
            sel_data[7] = 1'b1;
        port_beat(PORT_SEL, 1'b1, sel_data);
        port_beat(PORT_CTL, 1'b1, 8'h04 | 8'($urandom_range(0, 3)));
        repeat ($urandom_range(0, 3)) port_beat(PORT_CTL, 1'b0, 8'h00);
        port_beat(PORT_CTL, 1'b1, 8'h80 | ($urandom_range(0, 1) ? 8'h04 : 8'h00));
        repeat ($urandom_range(1, 6)) port_beat(PORT_DATA, 1'b1, 8'($urandom));
        port_beat(PORT_CTL, 1'b1, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'h00);
        repeat ($urandom_range(1, 8)) port_beat(PORT_DATA, 1'b0, 8'h00);
        if ($urandom_range(0, 3) == 0)
            port_beat(PORT_CTL, 1'b1, 8'h08);
        port_beat(PORT_SEL, 1'b0, 8'h00);
    endtask

    task automatic noise_beats();
        repeat ($urandom_range(1, 4))
            send_beat(1'($urandom), 2'($urandom), 1'($urandom), 8'($urandom), 24'($urandom));
    endtask

    task automatic test_random(input int beats);
        int stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
            if ($urandom_range(0, 9) < 7)
                drive_session();
            else
                noise_beats();
    endtask

    // ---------------------------------------------------------------- checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (read_bytes_q.size() == 0)
                report("beat with nothing expected", m_tdata, 8'h00);
            else
            begin
                logic [7:0] want;
                want = read_bytes_q.pop_front();
                if (m_tdata !== want)
                    report("read_data", m_tdata, want);
            end
        end
    end

    // output back-pressure in short bursts
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- sequence
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        beats_sent = 0;
        quiet     = 1'b0;
        attached_q = 8'h00;
        locked_q   = 8'h00;
        sel_drive  = NO_SEL;
        dirty      = 1'b0;
        for (int d = 0; d < DRIVES; d++)
        begin
            trk[d] = 0;
            spos[d] = 0;
            bptr[d] = 0;
            dstat[d] = 0;
        end
        foreach (sbuf[i])
            sbuf[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_masks(8'hff, 8'h00);
        test_track_limits();
        test_random(90);
        write_masks(8'($urandom), 8'($urandom));
        test_random(70);
        write_masks(8'h00, 8'hff);                // nothing attached
        test_random(30);
        write_masks(8'hff, 8'hff);
        test_random(60);
        write_masks(8'($urandom) | 8'h11, 8'h00);
        quiet = 1'b1;                             // last phase runs flat out
        test_random(60);

        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
